### hw/rtl/csv_field_tokenizer_assert.svh
// Assertion macros for the CSV field tokenizer.
// Each takes a label, clock, active-low reset, antecedent and consequent.
`ifndef CSV_FIELD_TOKENIZER_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_ASSERT_SVH

`ifndef ASSERT_OFF
`define CFT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cft assertion failed");
`define CFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cft assertion failed");
`else
`define CFT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define CFT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/cft_pkg.sv
`timescale 1ns / 1ps

package cft_pkg;

    localparam int CHAR_W          = 16;
    localparam int KIND_W          = 2;
    localparam int IDX_W           = 8;
    localparam int LINE_NUM_W      = 16;
    localparam int MAX_LINE_CHARS  = 4096;
    localparam int MAX_FIELD_CHARS = 1024;
    localparam int MAX_FIELDS      = 256;
    localparam int LINE_CNT_W      = $clog2(MAX_LINE_CHARS + 1);
    localparam int FIELD_CNT_W     = $clog2(MAX_FIELD_CHARS + 1);
    localparam int FIELD_SAT       = (MAX_FIELDS - 1 < 255) ? MAX_FIELDS - 1 : 255;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] REG_START_LINE   = APB_ADDR_W'(0);
    localparam logic [LINE_NUM_W-1:0] START_LINE_RESET = LINE_NUM_W'(2);

    localparam logic [CHAR_W-1:0] CH_COMMA = CHAR_W'(16'h002C);
    localparam logic [CHAR_W-1:0] CH_QUOTE = CHAR_W'(16'h0022);
    localparam logic [CHAR_W-1:0] CH_LF    = CHAR_W'(16'h000A);
    localparam logic [CHAR_W-1:0] CH_CR    = CHAR_W'(16'h000D);

    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_COMMA,
        CLS_QUOTE,
        CLS_EOL,
        CLS_EOD
    } t_cls;

    typedef enum logic [KIND_W-1:0] {
        KIND_CHAR = 2'd0,
        KIND_FEND = 2'd1,
        KIND_REND = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        TALLY_NONE = 2'd0,
        TALLY_ODD  = 2'd1,
        TALLY_EVEN = 2'd2
    } t_tally;

    typedef struct packed {
        t_cls              cls;
        logic [CHAR_W-1:0] ch;
    } t_entry;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } t_q_status;

endpackage

### hw/rtl/cft_ifs.sv
`timescale 1ns / 1ps

interface cft_in_if;
    logic                        valid;
    logic                        ready;
    logic [cft_pkg::CHAR_W-1:0]  char_code;
    logic                        end_of_data;

    modport source (output valid, output char_code, output end_of_data, input ready);
    modport sink   (input valid, input char_code, input end_of_data, output ready);
endinterface

interface cft_out_if;
    logic                        valid;
    logic                        ready;
    logic [cft_pkg::KIND_W-1:0]  out_kind;
    logic [cft_pkg::CHAR_W-1:0]  out_char;
    logic [cft_pkg::IDX_W-1:0]   field_index;
    logic                        is_header;
    logic                        truncated;
    logic                        last_in_row;

    modport source (output valid, output out_kind, output out_char, output field_index,
                    output is_header, output truncated, output last_in_row, input ready);
    modport sink   (input valid, input out_kind, input out_char, input field_index,
                    input is_header, input truncated, input last_in_row, output ready);
endinterface

### hw/rtl/cft_front.sv
`timescale 1ns / 1ps

module cft_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cft_in_if.sink             i_in,
    input  cft_pkg::t_q_status i_q_status,
    output logic               o_push,
    output cft_pkg::t_entry    o_entry
);
    import cft_pkg::*;

    logic   r_valid;
    t_entry r_entry;
    t_entry n_entry;
    logic   accept;

    always_comb begin
        n_entry.ch = i_in.char_code;
        if (i_in.end_of_data) begin
            n_entry.cls = CLS_EOD;
        end else if (i_in.char_code == CH_LF || i_in.char_code == CH_CR) begin
            n_entry.cls = CLS_EOL;
        end else if (i_in.char_code == CH_COMMA) begin
            n_entry.cls = CLS_COMMA;
        end else if (i_in.char_code == CH_QUOTE) begin
            n_entry.cls = CLS_QUOTE;
        end else begin
            n_entry.cls = CLS_OTHER;
        end
    end

    assign o_push     = r_valid && !i_q_status.full;
    assign i_in.ready = !r_valid || !i_q_status.full;
    assign accept     = i_in.valid && i_in.ready;
    assign o_entry    = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= n_entry;
        end
    end

endmodule

### hw/rtl/cft_queue.sv
`timescale 1ns / 1ps

module cft_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cft_pkg::t_entry     i_entry,
    input  logic                i_pop,
    output cft_pkg::t_entry     o_head,
    output cft_pkg::t_q_status  o_status
);
    import cft_pkg::*;

    t_entry               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;

    assign o_head          = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty  = (r_count == '0);
    assign o_status.count  = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

### hw/rtl/cft_back.sv
`timescale 1ns / 1ps

module cft_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [cft_pkg::LINE_NUM_W-1:0]  i_start_line,
    input  cft_pkg::t_entry                 i_head,
    input  cft_pkg::t_q_status              i_q_status,
    output logic                            o_pop,
    cft_out_if.source                       o_out
);
    import cft_pkg::*;

    localparam logic [LINE_CNT_W-1:0]  LINE_MAX  = LINE_CNT_W'(MAX_LINE_CHARS);
    localparam logic [FIELD_CNT_W-1:0] FIELD_MAX = FIELD_CNT_W'(MAX_FIELD_CHARS);
    localparam logic [IDX_W-1:0]       IDX_SAT   = IDX_W'(FIELD_SAT);

    // tokenizer state
    logic [LINE_NUM_W-1:0]  r_line_number,  n_line_number;
    logic [LINE_CNT_W-1:0]  r_line_chars,   n_line_chars;
    logic                   r_field_active, n_field_active;
    logic                   r_field_quoted, n_field_quoted;
    t_tally                 r_tally,        n_tally;
    logic                   r_prev_quote,   n_prev_quote;
    logic [FIELD_CNT_W-1:0] r_field_chars,  n_field_chars;
    logic [IDX_W-1:0]       r_field_number, n_field_number;
    logic                   r_drop_seen,    n_drop_seen;

    // output register
    logic                   r_out_valid;
    t_kind                  r_kind,   n_kind;
    logic [CHAR_W-1:0]      r_char,   n_char;
    logic [IDX_W-1:0]       r_idx,    n_idx;
    logic                   r_hdr,    n_hdr;
    logic                   r_trunc,  n_trunc;
    logic                   r_last,   n_last;
    logic                   n_result;

    logic                   advance;
    logic [LINE_NUM_W:0]    cur_line;
    logic                   skipped;
    logic                   hdr;
    logic                   first;
    logic                   is_q;
    logic                   is_comma;
    logic                   quoted;
    t_tally                 tally;
    logic                   even;
    logic                   end_field;
    logic                   emit;

    assign advance = !r_out_valid || o_out.ready;
    assign o_pop   = !i_q_status.empty && advance;

    assign cur_line = {1'b0, r_line_number} + (LINE_NUM_W + 1)'(1);
    assign skipped  = cur_line < {1'b0, i_start_line};
    assign hdr      = cur_line == {1'b0, i_start_line};

    always_comb begin
        n_line_number  = r_line_number;
        n_line_chars   = r_line_chars;
        n_field_active = r_field_active;
        n_field_quoted = r_field_quoted;
        n_tally        = r_tally;
        n_prev_quote   = r_prev_quote;
        n_field_chars  = r_field_chars;
        n_field_number = r_field_number;
        n_drop_seen    = r_drop_seen;
        n_result       = 1'b0;
        n_kind         = KIND_CHAR;
        n_char         = '0;
        n_idx          = r_field_number;
        n_hdr          = hdr;
        n_trunc        = 1'b0;
        n_last         = 1'b0;

        first     = !r_field_active;
        is_q      = i_head.cls == CLS_QUOTE;
        is_comma  = i_head.cls == CLS_COMMA;
        quoted    = first ? is_q : r_field_quoted;
        tally     = first ? TALLY_NONE : r_tally;
        if (quoted && is_q) begin
            tally = (tally == TALLY_ODD) ? TALLY_EVEN : TALLY_ODD;
        end
        even      = tally == TALLY_EVEN;
        if (!quoted) begin
            end_field = is_comma;
            emit      = !is_comma;
        end else begin
            end_field = even && r_prev_quote && is_comma;
            emit      = !end_field && !(is_q && even) && !first;
        end

        if (i_head.cls == CLS_EOL || i_head.cls == CLS_EOD) begin
            if (r_line_chars != '0) begin
                if (!skipped) begin
                    n_result = 1'b1;
                    n_kind   = r_field_active ? KIND_FEND : KIND_REND;
                    n_trunc  = r_drop_seen;
                    n_last   = 1'b1;
                end
                if (r_line_number != '1) begin
                    n_line_number = r_line_number + LINE_NUM_W'(1);
                end
                n_line_chars   = '0;
                n_field_active = 1'b0;
                n_field_quoted = 1'b0;
                n_tally        = TALLY_NONE;
                n_prev_quote   = 1'b0;
                n_field_chars  = '0;
                n_field_number = '0;
                n_drop_seen    = 1'b0;
            end
            if (i_head.cls == CLS_EOD) begin
                n_line_number = '0;
            end
        end else if (r_line_chars >= LINE_MAX) begin
            // line overflow: ignore the character entirely
            n_drop_seen = 1'b1;
        end else begin
            n_line_chars = r_line_chars + LINE_CNT_W'(1);
            if (!skipped) begin
                n_field_active = 1'b1;
                n_field_quoted = quoted;
                n_tally        = tally;
                n_prev_quote   = is_q;
                n_field_chars  = first ? '0 : r_field_chars;
                if (end_field) begin
                    n_result       = 1'b1;
                    n_kind         = KIND_FEND;
                    n_trunc        = r_drop_seen;
                    n_field_active = 1'b0;
                    n_field_quoted = 1'b0;
                    n_tally        = TALLY_NONE;
                    n_field_chars  = '0;
                    n_drop_seen    = 1'b0;
                    if (r_field_number < IDX_SAT) begin
                        n_field_number = r_field_number + IDX_W'(1);
                    end
                end else if (emit) begin
                    if (n_field_chars < FIELD_MAX) begin
                        n_field_chars = n_field_chars + FIELD_CNT_W'(1);
                        n_result      = 1'b1;
                        n_char        = i_head.ch;
                    end else begin
                        n_drop_seen = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_number  <= '0;
            r_line_chars   <= '0;
            r_field_active <= 1'b0;
            r_field_quoted <= 1'b0;
            r_tally        <= TALLY_NONE;
            r_prev_quote   <= 1'b0;
            r_field_chars  <= '0;
            r_field_number <= '0;
            r_drop_seen    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_line_number  <= n_line_number;
                r_line_chars   <= n_line_chars;
                r_field_active <= n_field_active;
                r_field_quoted <= n_field_quoted;
                r_tally        <= n_tally;
                r_prev_quote   <= n_prev_quote;
                r_field_chars  <= n_field_chars;
                r_field_number <= n_field_number;
                r_drop_seen    <= n_drop_seen;
            end
            if (advance) begin
                r_out_valid <= o_pop && n_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && n_result) begin
            r_kind  <= n_kind;
            r_char  <= n_char;
            r_idx   <= n_idx;
            r_hdr   <= n_hdr;
            r_trunc <= n_trunc;
            r_last  <= n_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_kind    = r_kind;
    assign o_out.out_char    = r_char;
    assign o_out.field_index = r_idx;
    assign o_out.is_header   = r_hdr;
    assign o_out.truncated   = r_trunc;
    assign o_out.last_in_row = r_last;

endmodule

### hw/rtl/csv_field_tokenizer.sv
// A result item passes through the front-end register, the queue and the back-end
// output register. Throughput: one input item per cycle while the queue is not full;
// the tokenizer step in the back end bounds it, and a 4-entry queue lets either side stall on its own.
// Reset (i_rst_n, synchronous, active low): line and field state cleared,
// queue emptied, start_line set to 2; no clearing pass is needed.
`timescale 1ns / 1ps

`include "csv_field_tokenizer_assert.svh"

module csv_field_tokenizer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cft_in_if.sink                          i_in,
    cft_out_if.source                       o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cft_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [cft_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [cft_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import cft_pkg::*;

    logic [LINE_NUM_W-1:0] r_start_line;
    t_q_status             q_status;
    t_entry                push_entry;
    t_entry                head;
    logic                  push;
    logic                  pop;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_START_LINE) ? APB_DATA_W'(r_start_line) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_line <= START_LINE_RESET;
        end else if (psel && penable && pwrite && pready && paddr == REG_START_LINE) begin
            r_start_line <= pwdata[LINE_NUM_W-1:0];
        end
    end

    cft_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    cft_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    cft_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start_line (r_start_line),
        .i_head       (head),
        .i_q_status   (q_status),
        .o_pop        (pop),
        .o_out        (o_out)
    );

    `CFT_ASSERT_IMPLIES(a_char_not_closing, i_clk, i_rst_n, o_out.valid && o_out.out_kind == KIND_CHAR, !o_out.truncated && !o_out.last_in_row)
    `CFT_ASSERT_IMPLIES(a_end_has_no_char, i_clk, i_rst_n, o_out.valid && o_out.out_kind != KIND_CHAR, o_out.out_char == '0)
    `CFT_ASSERT_IMPLIES(a_pop_nonempty, i_clk, i_rst_n, pop, q_status.count != '0)
    `CFT_ASSERT_NEXT(a_full_blocks_input, i_clk, i_rst_n, q_status.full && !pop, q_status.count == Q_CNT_W'(Q_DEPTH))

endmodule

### tb/sv/csv_token_checker.sv
`timescale 1ns / 1ps

module csv_token_checker
    import cft_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cft_in_if                     i_chars,
    cft_out_if                    i_tokens,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_results
);

    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        logic              hdr;
        logic              trunc;
        logic              last;
    } token_t;

    // Tokenizer state as the block should hold it
    logic [LINE_NUM_W-1:0] header_line;
    logic [LINE_NUM_W-1:0] line_num;
    logic [12:0]           line_chars;
    logic                  fld_active;
    logic                  fld_quoted;
    t_tally                tally;
    logic                  prev_quote;
    logic [10:0]           fld_chars;
    logic [IDX_W-1:0]      fld_num;
    logic                  dropped;

    token_t expected_tokens[$];
    int     errors  = 0;
    int     checked = 0;

    function automatic void clear_line();
        line_chars = '0;
        fld_active = 1'b0;
        fld_quoted = 1'b0;
        tally      = TALLY_NONE;
        prev_quote = 1'b0;
        fld_chars  = '0;
        fld_num    = '0;
        dropped    = 1'b0;
    endfunction

    // Advance the tokenizer by one character; return 1 when it yields a token
    function automatic bit tokenize_char(input logic [CHAR_W-1:0] ch, input logic eod,
                                         output token_t tok);
        logic [LINE_NUM_W:0] cur;
        bit skip, hdr, first, is_q, end_fld, emit, even;
        cur     = {1'b0, line_num} + 1'b1;
        skip    = cur < {1'b0, header_line};
        hdr     = cur == {1'b0, header_line};
        end_fld = 1'b0;
        emit    = 1'b0;
        tok     = '0;
        tok.hdr = hdr;
        tok.idx = fld_num;

        if (eod || ch == CH_LF || ch == CH_CR) begin
            bit made;
            made = 1'b0;
            if (line_chars != 0) begin
                if (!skip) begin
                    tok.kind  = fld_active ? KIND_FEND : KIND_REND;
                    tok.trunc = dropped;
                    tok.last  = 1'b1;
                    made      = 1'b1;
                end
                if (line_num != '1)
                    line_num++;
                clear_line();
            end
            if (eod)
                line_num = '0;
            return made;
        end

        // past the line limit every character but a line end is ignored, commas included
        if (line_chars >= MAX_LINE_CHARS) begin
            dropped = 1'b1;
            return 1'b0;
        end
        line_chars++;
        if (skip)
            return 1'b0;

        first = !fld_active;
        is_q  = ch == CH_QUOTE;
        if (first) begin
            fld_active = 1'b1;
            fld_quoted = is_q;
            tally      = TALLY_NONE;
            fld_chars  = '0;
        end
        if (!fld_quoted) begin
            if (ch == CH_COMMA)
                end_fld = 1'b1;
            else
                emit = 1'b1;
        end else begin
            if (is_q)
                tally = (tally == TALLY_ODD) ? TALLY_EVEN : TALLY_ODD;
            even = tally == TALLY_EVEN;
            if (even && prev_quote && ch == CH_COMMA)
                end_fld = 1'b1;
            else if (!(is_q && even) && !first)
                emit = 1'b1;
        end
        prev_quote = is_q;

        if (end_fld) begin
            tok.kind   = KIND_FEND;
            tok.trunc  = dropped;
            fld_active = 1'b0;
            fld_quoted = 1'b0;
            tally      = TALLY_NONE;
            fld_chars  = '0;
            dropped    = 1'b0;
            if (fld_num < FIELD_SAT)
                fld_num++;
            return 1'b1;
        end
        if (emit) begin
            if (fld_chars < MAX_FIELD_CHARS) begin
                fld_chars++;
                tok.kind = KIND_CHAR;
                tok.ch   = ch;
                return 1'b1;
            end
            dropped = 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        token_t want, tok;
        if (!i_rst_n) begin
            header_line = START_LINE_RESET;
            line_num    = '0;
            clear_line();
            expected_tokens.delete();
        end else begin
            // compare first: a result never leaves in the cycle its item enters
            if (i_tokens.valid && i_tokens.ready) begin
                checked++;
                if (expected_tokens.size() == 0) begin
                    errors++;
                    $error("result item with nothing expected: kind %0h char %0h",
                           i_tokens.out_kind, i_tokens.out_char);
                end else begin
                    want = expected_tokens.pop_front();
                    check_field("out_kind", 32'(want.kind), 32'(i_tokens.out_kind));
                    check_field("out_char", 32'(want.ch), 32'(i_tokens.out_char));
                    check_field("field_index", 32'(want.idx), 32'(i_tokens.field_index));
                    check_field("is_header", 32'(want.hdr), 32'(i_tokens.is_header));
                    check_field("truncated", 32'(want.trunc), 32'(i_tokens.truncated));
                    check_field("last_in_row", 32'(want.last), 32'(i_tokens.last_in_row));
                end
            end
            if (psel && penable && pwrite && pready && paddr == REG_START_LINE)
                header_line = pwdata[LINE_NUM_W-1:0];
            if (i_chars.valid && i_chars.ready) begin
                if (tokenize_char(i_chars.char_code, i_chars.end_of_data, tok))
                    expected_tokens.insert(expected_tokens.size(), tok);
            end
        end
        o_pending    <= expected_tokens.size();
        o_fail_count <= errors;
        o_results    <= checked;
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import cft_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int NUM_PHASES     = 7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int tokens_pending;
    int tokens_checked;
    int chars_sent  = 0;
    int send_idle   = 0;
    int recv_stall  = 0;
    int idle_cycles = 0;

    cft_in_if  in_if ();
    cft_out_if out_if ();

    csv_field_tokenizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    csv_token_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_chars      (in_if),
        .i_tokens     (out_if),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (tokens_pending),
        .o_results    (tokens_checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [CHAR_W-1:0] text_char();
        logic [CHAR_W-1:0] c;
        do begin
            c = ($urandom_range(0, 3) == 0) ? CHAR_W'($urandom) : CHAR_W'($urandom_range(32, 126));
        end while (c == CH_COMMA || c == CH_QUOTE || c == CH_LF || c == CH_CR);
        return c;
    endfunction

    task automatic send_item(input logic [CHAR_W-1:0] ch, input logic eod);
        while ($urandom_range(0, 99) < send_idle) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.char_code   <= ch;
        in_if.end_of_data <= eod;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        chars_sent++;
    endtask

    // Hold the sender until every expected result is out, then let the pipe empty
    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (tokens_pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_line();
        int nfields;
        int style;
        int len;
        nfields = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
        for (int f = 0; f < nfields; f++) begin
            style = $urandom_range(0, 5);
            len   = $urandom_range(0, 6);
            if (style <= 1) begin
                send_item(CH_QUOTE, 1'b0);
                repeat (len) begin
                    case ($urandom_range(0, 4))
                        0: send_item(CH_COMMA, 1'b0);
                        1: begin
                            send_item(CH_QUOTE, 1'b0);
                            send_item(CH_QUOTE, 1'b0);
                        end
                        default: send_item(text_char(), 1'b0);
                    endcase
                end
                send_item(CH_QUOTE, 1'b0);
            end else if (style != 2) begin
                repeat (len + 1) send_item(text_char(), 1'b0);
            end
            if (f != nfields - 1)
                send_item(CH_COMMA, 1'b0);
        end
        case ($urandom_range(0, 9))
            0: send_item(CH_CR, 1'b0);
            1: begin
                send_item(CH_CR, 1'b0);
                send_item(CH_LF, 1'b0);
            end
            2: send_item(CHAR_W'($urandom), 1'b1);
            3: begin
                send_item(CH_COMMA, 1'b0);
                send_item(CH_LF, 1'b0);
            end
            default: send_item(CH_LF, 1'b0);
        endcase
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 7))
                0: send_item(CH_COMMA, 1'b0);
                1: send_item(CH_QUOTE, 1'b0);
                2: send_item(CH_LF, 1'b0);
                3: send_item(CH_CR, 1'b0);
                4: send_item(CHAR_W'($urandom), $urandom_range(0, 15) == 0);
                default: send_item(text_char(), 1'b0);
            endcase
        end
    endtask

    // More fields than the index holds: empty fields past saturation, then one with text
    task automatic send_wide_line();
        repeat (FIELD_SAT + 4) send_item(CH_COMMA, 1'b0);
        repeat (3) send_item(text_char(), 1'b0);
        send_item(CH_LF, 1'b0);
    endtask

    initial begin
        int unsigned header_at[NUM_PHASES];
        int          send_pct[NUM_PHASES];
        int          stall_pct[NUM_PHASES];
        int          quota[NUM_PHASES];
        int          goal;

        header_at = '{2, 1, 0, 65535, 3, 0, 2};
        send_pct  = '{0, 83, 0, 14, 14, 0, 0};
        stall_pct = '{0, 0, 83, 14, 14, 0, 83};
        quota     = '{110, 120, 120, 40, 110, 100, 60};

        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.char_code   <= '0;
        in_if.end_of_data <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        header_at[5]       = $urandom_range(1, 5);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // end of data and an empty line with nothing pending, then a skipped line
        send_item(16'h0000, 1'b1);
        send_item(CH_LF, 1'b0);
        send_item(16'h0061, 1'b0);
        send_item(CH_LF, 1'b0);
        // header: quoted field with doubled quote and inner comma, extreme codes
        send_item(CH_QUOTE, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_COMMA, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_COMMA, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(CH_COMMA, 1'b0);
        send_item(CH_CR, 1'b0);
        // stray text after the closing quote stays in the field
        send_item(CH_QUOTE, 1'b0);
        send_item(16'h0061, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(16'h0063, 1'b0);
        send_item(CH_COMMA, 1'b0);
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_LF, 1'b0);
        // end of data flushes a pending line
        send_item(16'h007A, 1'b0);
        send_item(16'hFFFF, 1'b1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                drain_results();
                write_reg(REG_START_LINE, APB_DATA_W'(header_at[ph]));
            end
            send_idle  = send_pct[ph];
            recv_stall = stall_pct[ph];
            send_item(CHAR_W'($urandom), 1'b1);
            if (ph == NUM_PHASES - 1) begin
                send_line();
                send_wide_line();
            end
            goal = chars_sent + quota[ph];
            while (chars_sent < goal) begin
                if ($urandom_range(0, 199) == 0)
                    drain_results();
                if ($urandom_range(0, 9) < 8)
                    send_line();
                else
                    send_noise();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d characters under %0d start_line settings; %0d result items checked.",
                 chars_sent, NUM_PHASES, tokens_checked);
        $display("Quoted and bare fields, doubled quotes, end of data, index saturation.");
        if (fail_count == 0 && tokens_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/cft_pkg.sv
hw/rtl/cft_ifs.sv
hw/rtl/cft_front.sv
hw/rtl/cft_queue.sv
hw/rtl/cft_back.sv
hw/rtl/csv_field_tokenizer.sv
tb/sv/csv_token_checker.sv
tb/sv/tb_top.sv
